// ----- hw/rtl/sjs_pkg.sv -----
`timescale 1ns / 1ps

package sjs_pkg;

    // Number of cells in the job queue.
    localparam int QUEUE_DEPTH = 16;

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;

    // Input command codes.
    localparam logic CMD_ARRIVAL    = 1'b0;
    localparam logic CMD_COMPLETION = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHARGE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CHARGE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // Contents of one queue cell.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
    } entry_t;

    // Command broadcast to the cells.
    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   key_id;
        logic [TIME_W-1:0] key_remaining;
        logic [TIME_W-1:0] elapsed;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/sjs_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted job queue. The cell compares the broadcast key with
// its own entry and, together with its left neighbor's verdict, decides whether
// to hold, charge elapsed time, take the new key, take the left entry or take the right entry.
module sjs_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  sjs_pkg::cell_ctrl_t ctrl,
    input  sjs_pkg::entry_t   left,
    input  logic              left_before,
    input  sjs_pkg::entry_t   right,
    output sjs_pkg::entry_t   entry,
    output logic              ahead
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [sjs_pkg::ID_W-1:0]       id_reg;
    logic [sjs_pkg::ID_W-1:0]       id_next;
    logic [sjs_pkg::TIME_W-1:0]     rem_reg;
    logic [sjs_pkg::TIME_W-1:0]     rem_next;

    // The new key goes ahead of this entry when its remaining time is smaller,
    // or equal with a smaller id; an empty cell always lets the key in.
    always_comb
    begin
        ahead = !valid_reg
             || (ctrl.key_remaining < rem_reg)
             || ((ctrl.key_remaining == rem_reg) && (ctrl.key_id < id_reg));
    end

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        rem_next   = rem_reg;
        case (ctrl.op)
            sjs_pkg::CELL_CHARGE:
            begin
                rem_next = (rem_reg > ctrl.elapsed) ? rem_reg - ctrl.elapsed : '0;
            end
            sjs_pkg::CELL_INSERT:
            begin
                if (ahead && left_before)
                begin
                    valid_next = left.valid;
                    id_next    = left.id;
                    rem_next   = left.remaining;
                end
                else if (ahead)
                begin
                    valid_next = 1'b1;
                    id_next    = ctrl.key_id;
                    rem_next   = ctrl.key_remaining;
                end
            end
            sjs_pkg::CELL_REMOVE:
            begin
                valid_next = right.valid;
                id_next    = right.id;
                rem_next   = right.remaining;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        rem_reg <= rem_next;
    end

    assign entry.valid     = valid_reg;
    assign entry.id        = id_reg;
    assign entry.remaining = rem_reg;

endmodule

// ----- hw/rtl/srpt_job_scheduler_unit.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-------------------------------------------
// in      | input     | in_valid/in_stall  | cmd, job_id, job_length, now
// out     | output    | out_valid/out_stall| schedule_valid, completion_time,
//         |           |                    | cancel_previous, completed_valid,
//         |           |                    | completed_id, running_id, idle, dropped
//
// Every input transaction produces exactly one output transaction. An item
// passes in turn through accept, charge of the running job, one parallel
// compare-and-shift step across the cell chain, and the result register load.
// The whole chain moves in that single compare-and-shift pass.
// Reset clears the valid bits of all cells, the start time and the control
// state; no clearing pass is needed. A stall on the output only delays the
// final load; the next input is accepted once the result is in the register.

module srpt_job_scheduler_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [sjs_pkg::ID_W-1:0]      job_id,
    input  logic [sjs_pkg::TIME_W-1:0]    job_length,
    input  logic [sjs_pkg::TIME_W-1:0]    now,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          schedule_valid,
    output logic [sjs_pkg::TIME_W:0]      completion_time,
    output logic                          cancel_previous,
    output logic                          completed_valid,
    output logic [sjs_pkg::ID_W-1:0]      completed_id,
    output logic [sjs_pkg::ID_W-1:0]      running_id,
    output logic                          idle,
    output logic                          dropped
);

    sjs_pkg::state_t state_reg;
    sjs_pkg::state_t state_next;

    // Captured transaction.
    logic                           cmd_reg;
    logic [sjs_pkg::ID_W-1:0]       id_reg;
    logic [sjs_pkg::TIME_W-1:0]     len_reg;
    logic [sjs_pkg::TIME_W-1:0]     now_reg;
    logic [sjs_pkg::TIME_W-1:0]     elapsed_reg;
    logic [sjs_pkg::TIME_W-1:0]     elapsed_next;
    logic [sjs_pkg::TIME_W-1:0]     last_start_reg;

    // Per-item flags, settled in the charge step before the chain moves.
    logic                           drop_reg;
    logic                           cancel_reg;
    logic                           comp_v_reg;
    logic [sjs_pkg::ID_W-1:0]       comp_id_reg;

    // Result register.
    logic                           out_valid_reg;
    logic                           sched_reg;
    logic [sjs_pkg::TIME_W:0]       ctime_reg;
    logic                           cancel_out_reg;
    logic                           comp_v_out_reg;
    logic [sjs_pkg::ID_W-1:0]       comp_id_out_reg;
    logic [sjs_pkg::ID_W-1:0]       running_reg;
    logic                           idle_reg;
    logic                           drop_out_reg;

    sjs_pkg::entry_t                cells [sjs_pkg::QUEUE_DEPTH];
    logic [sjs_pkg::QUEUE_DEPTH-1:0] before_vec;
    sjs_pkg::cell_ctrl_t            ctrl_head;
    sjs_pkg::cell_ctrl_t            ctrl_rest;

    logic                           accept;
    logic                           out_free;
    logic                           is_arrival;
    logic                           queue_full;
    logic                           queue_empty;
    logic                           sched_now;
    logic [sjs_pkg::TIME_W:0]       ctime_now;

    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign is_arrival  = (cmd_reg == sjs_pkg::CMD_ARRIVAL);
    // Valid cells always form a prefix, so the ends tell full and empty.
    assign queue_full  = cells[sjs_pkg::QUEUE_DEPTH-1].valid;
    assign queue_empty = !cells[0].valid;

    // Time going backwards counts as no elapsed time.
    assign elapsed_next = (now >= last_start_reg) ? now - last_start_reg : '0;

    // Head after the shift decides the schedule.
    assign sched_now = is_arrival ? !drop_reg : cells[0].valid;
    assign ctime_now = {1'b0, now_reg} + {1'b0, cells[0].remaining};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sjs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sjs_pkg::ST_CHARGE;
                end
            end
            sjs_pkg::ST_CHARGE:
            begin
                state_next = sjs_pkg::ST_SHIFT;
            end
            sjs_pkg::ST_SHIFT:
            begin
                state_next = sjs_pkg::ST_DONE;
            end
            sjs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sjs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sjs_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: input handshake and cell commands.
    always_comb
    begin
        in_stall                = 1'b1;
        ctrl_rest.op            = sjs_pkg::CELL_HOLD;
        ctrl_rest.key_id        = id_reg;
        ctrl_rest.key_remaining = len_reg;
        ctrl_rest.elapsed       = elapsed_reg;
        ctrl_head               = ctrl_rest;
        case (state_reg)
            sjs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            sjs_pkg::ST_CHARGE:
            begin
                // The running job pays for the time it has run so far.
                if (is_arrival && !queue_full && !queue_empty)
                begin
                    ctrl_head.op = sjs_pkg::CELL_CHARGE;
                end
            end
            sjs_pkg::ST_SHIFT:
            begin
                if (is_arrival && !drop_reg)
                begin
                    ctrl_rest.op = sjs_pkg::CELL_INSERT;
                    ctrl_head.op = sjs_pkg::CELL_INSERT;
                end
                else if (!is_arrival && comp_v_reg)
                begin
                    ctrl_rest.op = sjs_pkg::CELL_REMOVE;
                    ctrl_head.op = sjs_pkg::CELL_REMOVE;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // The chain: each cell sees its neighbors' entries and the left verdict.
    genvar gi;
    generate
        for (gi = 0; gi < sjs_pkg::QUEUE_DEPTH; gi++)
        begin : g_cell
            sjs_pkg::entry_t     left_entry;
            sjs_pkg::entry_t     right_entry;
            logic                left_bf;
            sjs_pkg::cell_ctrl_t cell_ctrl;

            if (gi == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_bf    = 1'b0;
                assign cell_ctrl  = ctrl_head;
            end
            else
            begin : g_mid
                assign left_entry = cells[gi-1];
                assign left_bf    = before_vec[gi-1];
                assign cell_ctrl  = ctrl_rest;
            end

            if (gi == sjs_pkg::QUEUE_DEPTH - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cells[gi+1];
            end

            sjs_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .left        (left_entry),
                .left_before (left_bf),
                .right       (right_entry),
                .entry       (cells[gi]),
                .ahead       (before_vec[gi])
            );
        end
    endgenerate

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sjs_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sjs_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (sched_now)
                begin
                    last_start_reg <= now_reg;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            id_reg      <= job_id;
            len_reg     <= job_length;
            now_reg     <= now;
            elapsed_reg <= elapsed_next;
        end

        if (state_reg == sjs_pkg::ST_CHARGE)
        begin
            drop_reg    <= is_arrival && queue_full;
            cancel_reg  <= is_arrival && !queue_full && !queue_empty;
            comp_v_reg  <= !is_arrival && !queue_empty;
            comp_id_reg <= queue_empty ? '0 : cells[0].id;
        end

        if (state_reg == sjs_pkg::ST_DONE && out_free)
        begin
            sched_reg       <= sched_now;
            ctime_reg       <= sched_now ? ctime_now : '0;
            cancel_out_reg  <= cancel_reg;
            comp_v_out_reg  <= comp_v_reg;
            comp_id_out_reg <= comp_v_reg ? comp_id_reg : '0;
            running_reg     <= cells[0].valid ? cells[0].id : '0;
            idle_reg        <= !cells[0].valid;
            drop_out_reg    <= drop_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign schedule_valid  = sched_reg;
    assign completion_time = ctime_reg;
    assign cancel_previous = cancel_out_reg;
    assign completed_valid = comp_v_out_reg;
    assign completed_id    = comp_id_out_reg;
    assign running_id      = running_reg;
    assign idle            = idle_reg;
    assign dropped         = drop_out_reg;

endmodule

// ----- test/srpt_job_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps

module srpt_job_scheduler_unit_tb;

    // Number of random transactions after the directed table.
    localparam int RANDOM_ITEMS = 450;
    // Cycles without any transaction on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to wait after the last result.
    localparam int TAIL_CYCLES = 20;
    // Width at which every result field is compared.
    localparam int CHK_W = sjs_pkg::TIME_W + 1;

    // One input transaction as the sender sees it.
    typedef struct packed {
        logic                       cmd;
        logic [sjs_pkg::ID_W-1:0]   id;
        logic [sjs_pkg::TIME_W-1:0] len;
        logic [sjs_pkg::TIME_W-1:0] now;
    } job_event_t;

    // One output transaction, field by field.
    typedef struct packed {
        logic                       schedule_valid;
        logic [sjs_pkg::TIME_W:0]   completion_time;
        logic                       cancel_previous;
        logic                       completed_valid;
        logic [sjs_pkg::ID_W-1:0]   completed_id;
        logic [sjs_pkg::ID_W-1:0]   running_id;
        logic                       idle;
        logic                       dropped;
    } sched_outcome_t;

    // One row of the directed table. When has_want is set, want is the result
    // written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        job_event_t     ev;
        logic           has_want;
        sched_outcome_t want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          cmd;
    logic [sjs_pkg::ID_W-1:0]      job_id;
    logic [sjs_pkg::TIME_W-1:0]    job_length;
    logic [sjs_pkg::TIME_W-1:0]    now;
    logic                          out_valid;
    logic                          out_stall;
    logic                          schedule_valid;
    logic [sjs_pkg::TIME_W:0]      completion_time;
    logic                          cancel_previous;
    logic                          completed_valid;
    logic [sjs_pkg::ID_W-1:0]      completed_id;
    logic [sjs_pkg::ID_W-1:0]      running_id;
    logic                          idle;
    logic                          dropped;

    srpt_job_scheduler_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .job_id          (job_id),
        .job_length      (job_length),
        .now             (now),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .schedule_valid  (schedule_valid),
        .completion_time (completion_time),
        .cancel_previous (cancel_previous),
        .completed_valid (completed_valid),
        .completed_id    (completed_id),
        .running_id      (running_id),
        .idle            (idle),
        .dropped         (dropped)
    );

    // The testbench's own copy of the job queue. Entries 0..job_count-1 are
    // live and sorted by remaining time, then by id; entry 0 is running.
    logic [sjs_pkg::ID_W-1:0]   job_ids   [sjs_pkg::QUEUE_DEPTH];
    logic [sjs_pkg::TIME_W-1:0] job_left  [sjs_pkg::QUEUE_DEPTH];
    int                         job_count;
    logic [sjs_pkg::TIME_W-1:0] run_start;

    // Results still owed by the block, oldest first.
    sched_outcome_t expected_outcomes[$];

    // The time that the random sender believes it is, and the completion
    // the block most recently scheduled, so completions can arrive on time.
    logic [sjs_pkg::TIME_W-1:0] sim_clock;
    logic [sjs_pkg::TIME_W:0]   pending_finish;
    bit                         pending_known;

    // When calm is set, neither side inserts gaps.
    bit                calm;

    int fail_count;
    int arrival_count;
    int completion_count;
    int drop_count;
    int empty_completion_count;
    int checked_count;
    int quiet_cycles;

    stim_row_t directed_rows[$];

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Predicts the block's result for one event and updates the local queue.
    // An arrival charges the running job for the time it has run, inserts the
    // new job at its sorted place (after any entry with an equal key), and
    // reschedules the head. A completion pops the head and starts the next job.
    function automatic sched_outcome_t predict_schedule(job_event_t ev);
        sched_outcome_t             res;
        int                         pos;
        logic [sjs_pkg::TIME_W-1:0] elapsed;
        res = '0;
        if (ev.cmd == sjs_pkg::CMD_ARRIVAL)
        begin
            arrival_count++;
            if (job_count >= sjs_pkg::QUEUE_DEPTH)
            begin
                // A full queue drops the job and leaves every bit of state alone.
                res.dropped = 1'b1;
                drop_count++;
            end
            else
            begin
                if (job_count > 0)
                begin
                    // Time running backwards counts as no time at all.
                    elapsed = (ev.now >= run_start) ? ev.now - run_start : '0;
                    job_left[0] = (job_left[0] > elapsed) ? job_left[0] - elapsed : '0;
                    res.cancel_previous = 1'b1;
                end
                pos = job_count;
                for (int i = 0; i < job_count; i++)
                begin
                    if (ev.len < job_left[i] || (ev.len == job_left[i] && ev.id < job_ids[i]))
                    begin
                        pos = i;
                        break;
                    end
                end
                for (int i = job_count; i > pos; i--)
                begin
                    job_ids[i]  = job_ids[i-1];
                    job_left[i] = job_left[i-1];
                end
                job_ids[pos]  = ev.id;
                job_left[pos] = ev.len;
                job_count++;
                res.schedule_valid  = 1'b1;
                res.completion_time = {1'b0, ev.now} + {1'b0, job_left[0]};
                run_start = ev.now;
            end
        end
        else
        begin
            completion_count++;
            if (job_count == 0)
            begin
                empty_completion_count++;
            end
            else
            begin
                res.completed_valid = 1'b1;
                res.completed_id    = job_ids[0];
                for (int i = 0; i + 1 < job_count; i++)
                begin
                    job_ids[i]  = job_ids[i+1];
                    job_left[i] = job_left[i+1];
                end
                job_count--;
                if (job_count > 0)
                begin
                    res.schedule_valid  = 1'b1;
                    res.completion_time = {1'b0, ev.now} + {1'b0, job_left[0]};
                    run_start = ev.now;
                end
            end
        end
        res.running_id = (job_count > 0) ? job_ids[0] : '0;
        res.idle       = (job_count == 0);
        return res;
    endfunction

    function automatic sched_outcome_t mk_outcome(logic sv, logic [sjs_pkg::TIME_W:0] ct,
                                                  logic cp, logic cv,
                                                  logic [sjs_pkg::ID_W-1:0] cid,
                                                  logic [sjs_pkg::ID_W-1:0] rid, logic idl,
                                                  logic drp);
        sched_outcome_t res;
        res = '{sv, ct, cp, cv, cid, rid, idl, drp};
        return res;
    endfunction

    function automatic stim_row_t mk_row(logic c, logic [sjs_pkg::ID_W-1:0] id,
                                         logic [sjs_pkg::TIME_W-1:0] len,
                                         logic [sjs_pkg::TIME_W-1:0] t, logic has_want,
                                         sched_outcome_t want);
        stim_row_t row;
        row.ev       = '{c, id, len, t};
        row.has_want = has_want;
        row.want     = want;
        return row;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Builds one random event. Mode 0 leans toward arrivals so the queue
    // fills and overflows, mode 1 leans toward completions so it drains,
    // and mode 2 keeps the two about even.
    function automatic job_event_t gen_event(int mode);
        job_event_t ev;
        int         r;
        int         arrive_pct;
        arrive_pct = (mode == 0) ? 85 : (mode == 1) ? 20 : 55;
        ev.cmd = ($urandom_range(0, 99) < arrive_pct) ? sjs_pkg::CMD_ARRIVAL
                                                      : sjs_pkg::CMD_COMPLETION;

        // Small ids make ties on the remaining time meet the id tie-break often.
        r = $urandom_range(0, 99);
        ev.id = (r < 70) ? 16'($urandom_range(0, 15)) : 16'($urandom);

        r = $urandom_range(0, 99);
        if (r < 10)
            ev.len = '0;
        else if (r < 70)
            ev.len = $urandom_range(1, 200);
        else if (r < 85)
            ev.len = $urandom_range(200, 100000);
        else
            ev.len = $urandom;

        r = $urandom_range(0, 99);
        if (ev.cmd == sjs_pkg::CMD_COMPLETION && pending_known && r < 70)
            sim_clock = pending_finish[sjs_pkg::TIME_W-1:0];
        else if (r < 85)
            sim_clock = sim_clock + $urandom_range(0, 150);
        else if (r < 94)
            sim_clock = sim_clock - $urandom_range(1, 300);
        else
            sim_clock = $urandom;
        ev.now = sim_clock;
        return ev;
    endfunction

    // Presents one transaction, after an optional gap, and returns at the edge
    // where it is accepted. Valid stays high when the next call has no gap.
    task automatic send_event(job_event_t ev, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd        <= ev.cmd;
        job_id     <= ev.id;
        job_length <= ev.len;
        now        <= ev.now;
        in_valid   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
    endtask

    // Sends one event and records the result the block owes for it.
    task automatic issue_event(job_event_t ev, logic has_want, sched_outcome_t want);
        sched_outcome_t pred;
        send_event(ev, gap_len());
        pred = predict_schedule(ev);
        expected_outcomes.push_back(has_want ? want : pred);
        if (pred.schedule_valid)
        begin
            pending_finish = pred.completion_time;
            pending_known  = 1'b1;
        end
        else if (pred.idle)
        begin
            pending_known = 1'b0;
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_outcomes();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_outcomes.size() != 0);
    endtask

    task automatic check_field(string name, logic [CHK_W-1:0] want, logic [CHK_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Output stall pattern. Each run of stall is followed by a cycle in which
    // the result can leave.
    initial
    begin
        int run;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = gap_len();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Result checker: every output transaction is compared with the oldest
    // expectation; a result with nothing owed is a failure on its own.
    always @(posedge clk)
    begin
        sched_outcome_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                fail_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                checked_count++;
                check_field("schedule_valid", CHK_W'(want.schedule_valid),
                            CHK_W'(schedule_valid));
                check_field("completion_time", want.completion_time, completion_time);
                check_field("cancel_previous", CHK_W'(want.cancel_previous),
                            CHK_W'(cancel_previous));
                check_field("completed_valid", CHK_W'(want.completed_valid),
                            CHK_W'(completed_valid));
                check_field("completed_id", CHK_W'(want.completed_id), CHK_W'(completed_id));
                check_field("running_id", CHK_W'(want.running_id), CHK_W'(running_id));
                check_field("idle", CHK_W'(want.idle), CHK_W'(idle));
                check_field("dropped", CHK_W'(want.dropped), CHK_W'(dropped));
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("srpt_job_scheduler_unit test failed");
                $finish;
            end
        end
    end

    // Main sequence: reset, the directed table, then random phases.
    initial
    begin
        int mode;
        job_event_t ev;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= sjs_pkg::CMD_ARRIVAL;
        job_id     <= '0;
        job_length <= '0;
        now        <= '0;

        job_count              = 0;
        run_start              = '0;
        sim_clock              = '0;
        pending_finish         = '0;
        pending_known          = 1'b0;
        calm                   = 1'b0;
        arrival_count          = 0;
        completion_count       = 0;
        drop_count             = 0;
        empty_completion_count = 0;

        // Completion on an empty queue: nothing happens and the block reports idle.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_COMPLETION, 16'd0, 32'd0, 32'd0, 1'b1,
                                       mk_outcome(1'b0, 33'd0, 1'b0, 1'b0, 16'd0, 16'd0,
                                                  1'b1, 1'b0)));
        // Arrival into an empty queue: scheduled at now + length, nothing cancelled.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd5, 32'd100, 32'd0, 1'b1,
                                       mk_outcome(1'b1, 33'd100, 1'b0, 1'b0, 16'd0, 16'd5,
                                                  1'b0, 1'b0)));
        // Completion that leaves the queue empty.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_COMPLETION, 16'd0, 32'd0, 32'd100, 1'b1,
                                       mk_outcome(1'b0, 33'd0, 1'b0, 1'b1, 16'd5, 16'd0,
                                                  1'b1, 1'b0)));
        // Largest id, length and time: the completion time needs its top bit.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 1'b1,
                                       mk_outcome(1'b1, 33'h1_FFFF_FFFE, 1'b0, 1'b0, 16'd0,
                                                  16'hFFFF, 1'b0, 1'b0)));
        // Time goes backwards and a zero-length job preempts the running one.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd0, 32'd0, 32'd10, 1'b1,
                                       mk_outcome(1'b1, 33'd10, 1'b1, 1'b0, 16'd0, 16'd0,
                                                  1'b0, 1'b0)));
        // Same remaining time and same id: the newcomer queues behind.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd0, 32'd0, 32'd10, 1'b0, '0));
        // Elapsed time beyond what is left: the head saturates at zero.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd3, 32'd5, 32'd20, 1'b0, '0));
        directed_rows.push_back(mk_row(sjs_pkg::CMD_COMPLETION, 16'd0, 32'd0, 32'd25, 1'b0,
                                       '0));
        // Equal remaining times with ids on both sides of the existing entry.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd4, 32'd5, 32'd30, 1'b0, '0));
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd2, 32'd5, 32'd30, 1'b0, '0));
        // Fill the queue to its last cell.
        for (int i = 0; i < sjs_pkg::QUEUE_DEPTH - 5; i++)
        begin
            directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'(100 + i),
                                           32'(1000 - 37 * i), 32'(40 + i), 1'b0, '0));
        end
        // Arrival into a full queue is dropped; the zero-length head keeps running.
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd7, 32'd1, 32'd60, 1'b1,
                                       mk_outcome(1'b0, 33'd0, 1'b0, 1'b0, 16'd0, 16'd0,
                                                  1'b0, 1'b1)));
        directed_rows.push_back(mk_row(sjs_pkg::CMD_COMPLETION, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'd0, 1'b0, '0));
        directed_rows.push_back(mk_row(sjs_pkg::CMD_ARRIVAL, 16'd9, 32'd0, 32'd70, 1'b0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue_event(directed_rows[i].ev, directed_rows[i].has_want, directed_rows[i].want);
        end
        drain_outcomes();
        sim_clock = 32'd1000;

        mode = 2;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // New phase every 40 transactions; about one in four runs flat out.
            if (k % 40 == 0)
            begin
                mode = $urandom_range(0, 2);
                calm = ($urandom_range(0, 3) == 0);
            end
            if (k == RANDOM_ITEMS / 2)
                drain_outcomes();
            ev = gen_event(mode);
            issue_event(ev, 1'b0, '0);
        end
        calm = 1'b0;

        drain_outcomes();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d arrivals (%0d dropped on a full queue) and %0d completions",
                 arrival_count, drop_count, completion_count);
        $display("(%0d on an empty queue); %0d result transactions checked.",
                 empty_completion_count, checked_count);
        if (fail_count == 0)
            $display("srpt_job_scheduler_unit test passed");
        else
            $display("srpt_job_scheduler_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sjs_pkg.sv
hw/rtl/sjs_cell.sv
hw/rtl/srpt_job_scheduler_unit.sv
test/srpt_job_scheduler_unit_tb.sv
